@@ src/vsab_pkg.sv @@
// Package for the alarm beep sequencer: widths, register indexes, modes and reset values.
`timescale 1ns / 1ps
`default_nettype none
package vsab_pkg;

	localparam int LIMIT_W      = 8;
	localparam int TONE_W       = 16;
	localparam int HEART_CNT_W  = 2;
	localparam int OXY_CNT_W    = 3;
	localparam int CFG_INDEX_W  = 3;
	localparam int IN_DATA_W    = 2 * LIMIT_W;
	localparam int OUT_DATA_W   = 1 + TONE_W + 1 + 1 + HEART_CNT_W + OXY_CNT_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HEART_LOW   = 3'd0,
		REG_HEART_HIGH  = 3'd1,
		REG_OXY_LOW     = 3'd2,
		REG_OXY_HIGH    = 3'd3,
		REG_HEART_TONE  = 3'd4,
		REG_OXY_TONE    = 3'd5
	} cfg_reg_t;

	localparam logic MODE_CHECK = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam logic [LIMIT_W-1:0] HEART_LOW_RST  = 8'd50;
	localparam logic [LIMIT_W-1:0] HEART_HIGH_RST = 8'd120;
	localparam logic [LIMIT_W-1:0] OXY_LOW_RST    = 8'd90;
	localparam logic [LIMIT_W-1:0] OXY_HIGH_RST   = 8'd100;
	localparam logic [TONE_W-1:0]  HEART_TONE_RST = 16'd100;
	localparam logic [TONE_W-1:0]  OXY_TONE_RST   = 16'd200;

	localparam logic [HEART_CNT_W-1:0] HEART_BEEPS_LOW  = 2'd1;
	localparam logic [HEART_CNT_W-1:0] HEART_BEEPS_HIGH = 2'd2;
	localparam logic [OXY_CNT_W-1:0]   OXY_BEEPS_LOW    = 3'd3;
	localparam logic [OXY_CNT_W-1:0]   OXY_BEEPS_HIGH   = 3'd4;

	typedef struct packed {
		logic                    tone_on;
		logic [TONE_W-1:0]       tone_level;
		logic                    ticking;
		logic                    long_gap;
		logic [HEART_CNT_W-1:0]  heart_cnt;
		logic [OXY_CNT_W-1:0]    oxy_cnt;
	} beep_state_t;

endpackage
`default_nettype wire

@@ src/vital_sign_alarm_beeper.sv @@
// Top level of the alarm beep sequencer: input register, next-state logic and result register.
//
// Channel   Direction  Width  Content
// s_axis    in         16+1   tdata: heart_rate, oxygen_level; tuser: mode
// m_axis    out        24     tdata: beeper state after the item
// cfg       in         3+16   register index and write data
//
// An item is held in the input register and then in the result register, which drives m_axis.
// One item is taken per cycle while m_axis does not stall; the rate is set by the single state update per item.
// A stall on m_axis holds the result register and stops the input register from advancing.
// arst_n clears the state, the valid flags and the limits and tones to their defaults.
// Configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none
module vital_sign_alarm_beeper
	import vsab_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// [7:0] heart_rate, [15:8] oxygen_level
	input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,
	// [0] mode
	input  wire logic                    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// [0] tone_on, [16:1] tone_level, [17] ticking, [18] long_gap,
	// [20:19] heart_beeps_left, [23:21] oxygen_beeps_left
	output logic [OUT_DATA_W-1:0]        m_axis_tdata,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [TONE_W-1:0]       cfg_data
);

	logic [LIMIT_W-1:0] heart_low_q, heart_high_q, oxy_low_q, oxy_high_q;
	logic [TONE_W-1:0]  heart_tone_q, oxy_tone_q;

	logic               valid_s1;
	logic               mode_s1;
	logic [LIMIT_W-1:0] heart_rate_s1, oxy_level_s1;

	beep_state_t        state_q, state_nxt;
	logic               out_valid_q;
	logic               advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {state_q.oxy_cnt, state_q.heart_cnt, state_q.long_gap,
		state_q.ticking, state_q.tone_level, state_q.tone_on};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heart_low_q  <= HEART_LOW_RST;
			heart_high_q <= HEART_HIGH_RST;
			oxy_low_q    <= OXY_LOW_RST;
			oxy_high_q   <= OXY_HIGH_RST;
			heart_tone_q <= HEART_TONE_RST;
			oxy_tone_q   <= OXY_TONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEART_LOW:  heart_low_q  <= cfg_data[LIMIT_W-1:0];
				REG_HEART_HIGH: heart_high_q <= cfg_data[LIMIT_W-1:0];
				REG_OXY_LOW:    oxy_low_q    <= cfg_data[LIMIT_W-1:0];
				REG_OXY_HIGH:   oxy_high_q   <= cfg_data[LIMIT_W-1:0];
				REG_HEART_TONE: heart_tone_q <= cfg_data;
				REG_OXY_TONE:   oxy_tone_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1       <= s_axis_tuser;
			heart_rate_s1 <= s_axis_tdata[LIMIT_W-1:0];
			oxy_level_s1  <= s_axis_tdata[IN_DATA_W-1:LIMIT_W];
		end
	end

	// Next beeper state for the item in the input register.
	always_comb begin
		logic gap_now;
		state_nxt = state_q;
		gap_now   = 1'b0;
		if (mode_s1 == MODE_CHECK) begin
			if (heart_rate_s1 <= heart_low_q) begin
				state_nxt.heart_cnt = HEART_BEEPS_LOW;
			end else if (heart_rate_s1 >= heart_high_q) begin
				state_nxt.heart_cnt = HEART_BEEPS_HIGH;
			end
			if (oxy_level_s1 <= oxy_low_q) begin
				state_nxt.oxy_cnt = OXY_BEEPS_LOW;
			end else if (oxy_level_s1 >= oxy_high_q) begin
				state_nxt.oxy_cnt = OXY_BEEPS_HIGH;
			end
			if (state_nxt.heart_cnt != '0 || state_nxt.oxy_cnt != '0) begin
				state_nxt.long_gap   = 1'b0;
				state_nxt.tone_level = heart_tone_q;
				state_nxt.ticking    = 1'b1;
			end
		end else if (state_q.ticking) begin
			gap_now = state_q.long_gap;
			// The end of the long gap either hands over to the oxygen beeps or stops the timer.
			if (state_q.long_gap) begin
				if (state_q.oxy_cnt != '0) begin
					gap_now = 1'b0;
				end else begin
					state_nxt.ticking = 1'b0;
				end
			end
			state_nxt.long_gap = gap_now;
			if (!gap_now) begin
				if (state_q.heart_cnt != '0) begin
					state_nxt.tone_on = !state_q.tone_on;
					if (state_q.tone_on) begin
						state_nxt.heart_cnt = state_q.heart_cnt - HEART_CNT_W'(1);
						if (state_q.heart_cnt == HEART_CNT_W'(1)) begin
							state_nxt.long_gap = 1'b1;
						end
					end
				end else if (state_q.oxy_cnt != '0) begin
					state_nxt.tone_on = !state_q.tone_on;
					if (!state_q.tone_on) begin
						state_nxt.tone_level = oxy_tone_q;
					end else begin
						state_nxt.oxy_cnt = state_q.oxy_cnt - OXY_CNT_W'(1);
						if (state_q.oxy_cnt == OXY_CNT_W'(1)) begin
							state_nxt.ticking = 1'b0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
